// ----- rtl/tpic_pkg.sv -----
`timescale 1ns / 1ps

package tpic_pkg;

    // Field widths fixed by the item format
    localparam int TIME_W    = 31;
    localparam int DELTA_W   = 16;
    localparam int OP_W      = 3;
    localparam int FRAC_BITS_DEFAULT = 8;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TIME_W-1:0] TIME_MAX          = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] INITIAL_TIME_RST  = TIME_W'(3000);
    localparam logic [TIME_W-1:0] INCREMENT_TIME_RST = '0;

    // Register indexes, selected by paddr[2]
    typedef enum logic {
        REG_INITIAL_TIME   = 1'b0,
        REG_INCREMENT_TIME = 1'b1
    } reg_idx_t;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_SET_ACTIVE = 3'd3,
        OP_INCREMENT = 3'd4,
        OP_RESET     = 3'd5
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic               player;
        logic [DELTA_W-1:0] delta_time;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_a;
        logic [TIME_W-1:0] time_b;
        logic              is_running;
        logic              current_player;
        logic              time_changed;
        logic              expired;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] initial_time;
        logic [TIME_W-1:0] increment_time;
    } cfg_t;

endpackage

// ----- rtl/tpic_core.sv -----
`timescale 1ns / 1ps

module tpic_core #(
    parameter int FRAC_BITS = tpic_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  tpic_pkg::in_item_t  item,
    input  tpic_pkg::cfg_t      cfg,
    output tpic_pkg::out_item_t result
);
    import tpic_pkg::*;

    localparam int SUM_W = DELTA_W + 1;

    logic [TIME_W-1:0]    remaining_a_reg, remaining_a_next;
    logic [TIME_W-1:0]    remaining_b_reg, remaining_b_next;
    logic [FRAC_BITS-1:0] residue_a_reg, residue_a_next;
    logic [FRAC_BITS-1:0] residue_b_reg, residue_b_next;
    logic                 running_reg, running_next;
    logic                 active_reg, active_next;

    logic [TIME_W-1:0]    rem_sel;
    logic [FRAC_BITS-1:0] res_sel;
    logic [SUM_W-1:0]     tick_sum;
    logic [SUM_W-1:0]     tick_whole;
    logic [TIME_W-1:0]    whole_ext;
    logic [TIME_W-1:0]    tick_rem;
    logic [TIME_W-1:0]    inc_src;
    logic [TIME_W:0]      inc_sum;
    logic [TIME_W-1:0]    inc_rem;
    logic                 changed;
    logic                 expiry;

    // Tick datapath on the active player's residue and time
    assign rem_sel    = active_reg ? remaining_b_reg : remaining_a_reg;
    assign res_sel    = active_reg ? residue_b_reg : residue_a_reg;
    assign tick_sum   = SUM_W'(res_sel) + SUM_W'(item.delta_time);
    assign tick_whole = tick_sum >> FRAC_BITS;
    assign whole_ext  = TIME_W'(tick_whole);
    assign tick_rem   = (rem_sel > whole_ext) ? (rem_sel - whole_ext) : '0;

    // Saturating increment on the chosen player's time
    assign inc_src = item.player ? remaining_b_reg : remaining_a_reg;
    assign inc_sum = {1'b0, inc_src} + {1'b0, cfg.increment_time};
    assign inc_rem = inc_sum[TIME_W] ? TIME_MAX : inc_sum[TIME_W-1:0];

    // Next state for one operation
    always_comb begin
        remaining_a_next = remaining_a_reg;
        remaining_b_next = remaining_b_reg;
        residue_a_next   = residue_a_reg;
        residue_b_next   = residue_b_reg;
        running_next     = running_reg;
        active_next      = active_reg;
        changed          = 1'b0;
        expiry           = 1'b0;
        unique case (item.operation)
            OP_TICK: begin
                if (running_reg) begin
                    if (active_reg) begin
                        residue_b_next = tick_sum[FRAC_BITS-1:0];
                    end else begin
                        residue_a_next = tick_sum[FRAC_BITS-1:0];
                    end
                    if (tick_whole != '0) begin
                        changed = 1'b1;
                        if (active_reg) begin
                            remaining_b_next = tick_rem;
                        end else begin
                            remaining_a_next = tick_rem;
                        end
                        if (tick_rem == '0) begin
                            running_next = 1'b0;
                            expiry       = 1'b1;
                        end
                    end
                end
            end
            OP_START: begin
                active_next  = item.player;
                running_next = 1'b1;
            end
            OP_STOP: begin
                running_next = 1'b0;
            end
            OP_SET_ACTIVE: begin
                active_next = item.player;
            end
            OP_INCREMENT: begin
                if (cfg.increment_time != '0) begin
                    changed = 1'b1;
                    if (item.player) begin
                        remaining_b_next = inc_rem;
                    end else begin
                        remaining_a_next = inc_rem;
                    end
                end
            end
            OP_RESET: begin
                running_next     = 1'b0;
                remaining_a_next = cfg.initial_time;
                remaining_b_next = cfg.initial_time;
                residue_a_next   = '0;
                residue_b_next   = '0;
                changed          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Report the state left by this transaction
    always_comb begin
        result.time_a         = remaining_a_next;
        result.time_b         = remaining_b_next;
        result.is_running     = running_next;
        result.current_player = active_next;
        result.time_changed   = changed;
        result.expired        = expiry;
    end

    // Advance the game state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_a_reg <= '0;
            remaining_b_reg <= '0;
            residue_a_reg   <= '0;
            residue_b_reg   <= '0;
            running_reg     <= 1'b0;
            active_reg      <= 1'b0;
        end else if (step) begin
            remaining_a_reg <= remaining_a_next;
            remaining_b_reg <= remaining_b_next;
            residue_a_reg   <= residue_a_next;
            residue_b_reg   <= residue_b_next;
            running_reg     <= running_next;
            active_reg      <= active_next;
        end
    end

endmodule

// ----- rtl/two_player_increment_clock.sv -----
`timescale 1ns / 1ps

// Two-player game clock with increment. Each input transaction (tick, start, stop,
// set active, increment, reset) yields exactly one result carrying both remaining
// times in tenths and the running, active-player, changed and expiry flags. One
// transaction is taken every cycle while s_ready is high; its result is held in the
// output register, or in the skid register behind it, after the state update. A
// two-entry output buffer lets s_ready stay high while one result waits, so
// s_ready drops only when two results are held. Tick deltas are in units of
// 1/2^FRAC_BITS tenth. Registers: initial_time at 0x0 (reset 3000) and
// increment_time at 0x4 (reset 0); write them only while the clock is idle.
module two_player_increment_clock #(
    parameter int FRAC_BITS = tpic_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tpic_pkg::in_item_t                  s_data,
    // Result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output tpic_pkg::out_item_t                 m_data,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpic_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tpic_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tpic_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tpic_pkg::*;

    cfg_t      cfg_reg;
    out_item_t core_result;
    out_item_t out_reg;
    out_item_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      s_accept;
    logic      m_accept;
    logic      cfg_write;
    reg_idx_t  reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    // Hold the configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_time   <= INITIAL_TIME_RST;
            cfg_reg.increment_time <= INCREMENT_TIME_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_INITIAL_TIME:   cfg_reg.initial_time   <= pwdata[TIME_W-1:0];
                REG_INCREMENT_TIME: cfg_reg.increment_time <= pwdata[TIME_W-1:0];
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (reg_idx)
            REG_INITIAL_TIME:   prdata = APB_DATA_W'(cfg_reg.initial_time);
            REG_INCREMENT_TIME: prdata = APB_DATA_W'(cfg_reg.increment_time);
        endcase
    end

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign m_accept = out_valid_reg && m_ready;

    tpic_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_accept) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_accept;
                end
            end else if (s_accept) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (m_accept) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= core_result;
            end
        end else if (s_accept) begin
            if (out_valid_reg) begin
                skid_reg <= core_result;
            end else begin
                out_reg <= core_result;
            end
        end
    end

    // The skid stage only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result with the output register empty");

    // Expiry always stops the clock and reports a written time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.expired) |-> (!m_data.is_running && m_data.time_changed))
        else $error("expiry reported without stop or time change");

    // The expired player's time is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.expired) |->
            ((m_data.current_player && m_data.time_b == '0) ||
             (!m_data.current_player && m_data.time_a == '0)))
        else $error("expiry reported with the active time above zero");

endmodule
